// File: design/ptx_pkg.sv
// Shared types, constants and single-precision arithmetic for the point transform.
// Holds the pre-round and round halves of the float multiply and add.
// No dependencies.
package ptx_pkg;

  localparam int unsigned REG_COUNT = 8;
  localparam int unsigned ADDR_W    = 6;

  localparam logic [31:0] FP_ONE    = 32'h3F80_0000;
  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

  localparam logic [63:0] CFG_RESET [REG_COUNT] = '{
    64'h0000_0000_3F80_0000, 64'h0,
    64'h3F80_0000_0000_0000, 64'h0,
    64'h0,                   64'h0000_0000_3F80_0000,
    64'h0,                   64'h3F80_0000_0000_0000
  };

  typedef enum logic [1:0] {
    FC_NUM,
    FC_ZERO,
    FC_INF,
    FC_NAN
  } fp_cls_t;

  // value = sig / 2^49 * 2^(e - 127) when cls is FC_NUM
  typedef struct packed {
    fp_cls_t            cls;
    logic               sgn;
    logic signed [11:0] e;
    logic [49:0]        sig;
  } fp_mid_t;

  function automatic logic [23:0] fp_mant(input logic [31:0] a);
    return {a[30:23] != 8'd0, a[22:0]};
  endfunction

  function automatic logic [7:0] fp_eexp(input logic [31:0] a);
    return (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
  endfunction

  function automatic logic fp_is_nan(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  function automatic logic fp_is_inf(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
  endfunction

  function automatic logic fp_is_zero(input logic [31:0] a);
    return a[30:0] == 31'd0;
  endfunction

  function automatic logic [5:0] lzc50(input logic [49:0] v);
    logic [5:0] n;
    n = 6'd50;
    for (int i = 0; i < 50; i++) begin
      if (v[i]) n = 6'(49 - i);
    end
    return n;
  endfunction

  function automatic logic [31:0] fp_round(input logic sgn, input logic signed [11:0] e,
                                           input logic [49:0] sig);
    logic [5:0]         lz;
    logic signed [11:0] sh;
    logic signed [11:0] e2;
    logic [5:0]         rs;
    logic [99:0]        w;
    logic [49:0]        s2;
    logic [22:0]        mant;
    logic               g;
    logic               st;
    logic               inc;
    logic [30:0]        body;
    lz = lzc50(sig);
    if (e >= 12'sd1) begin
      if ((e - 12'sd1) > $signed({6'd0, lz})) sh = $signed({6'd0, lz});
      else sh = e - 12'sd1;
      s2 = sig << sh[5:0];
      e2 = e - sh;
    end else begin
      if (e < -12'sd49) rs = 6'd51;
      else rs = 6'(12'sd1 - e);
      w  = {sig, 50'd0} >> rs;
      s2 = w[99:50] | {49'd0, |w[49:0]};
      e2 = 12'sd1;
    end
    mant = s2[48:26];
    g    = s2[25];
    st   = |s2[24:0];
    inc  = g & (st | mant[0]);
    if (sig == 50'd0) return {sgn, 31'd0};
    if (e2 >= 12'sd255) return {sgn, 8'hFF, 23'd0};
    body = {(s2[49] ? e2[7:0] : 8'd0), mant} + {30'd0, inc};
    return {sgn, body};
  endfunction

  function automatic logic [31:0] fp_finish(input fp_mid_t m);
    logic [31:0] r;
    case (m.cls)
      FC_NAN:  r = CANON_NAN;
      FC_INF:  r = {m.sgn, 8'hFF, 23'd0};
      FC_ZERO: r = {m.sgn, 31'd0};
      default: r = fp_round(m.sgn, m.e, m.sig);
    endcase
    return r;
  endfunction

  function automatic fp_mid_t fmul_pre(input logic [31:0] a, input logic [31:0] b);
    fp_mid_t     m;
    logic [47:0] p;
    p     = fp_mant(a) * fp_mant(b);
    m.sgn = a[31] ^ b[31];
    m.e   = $signed({4'd0, fp_eexp(a)}) + $signed({4'd0, fp_eexp(b)}) - 12'sd126;
    m.sig = {p, 2'b00};
    if (fp_is_nan(a) || fp_is_nan(b) || (fp_is_inf(a) && fp_is_zero(b)) ||
        (fp_is_zero(a) && fp_is_inf(b))) m.cls = FC_NAN;
    else if (fp_is_inf(a) || fp_is_inf(b)) m.cls = FC_INF;
    else m.cls = FC_NUM;
    return m;
  endfunction

  function automatic fp_mid_t fadd_pre(input logic [31:0] a, input logic [31:0] b);
    fp_mid_t     m;
    logic [31:0] x;
    logic [31:0] y;
    logic [7:0]  d8;
    logic [5:0]  d;
    logic [99:0] w;
    logic [49:0] bx;
    logic [49:0] by;
    logic [49:0] sum;
    if (a[30:0] < b[30:0]) begin
      x = b;
      y = a;
    end else begin
      x = a;
      y = b;
    end
    d8  = fp_eexp(x) - fp_eexp(y);
    d   = (d8 > 8'd51) ? 6'd51 : d8[5:0];
    bx  = {1'b0, fp_mant(x), 25'd0};
    w   = {1'b0, fp_mant(y), 25'd0, 50'd0} >> d;
    by  = w[99:50] | {49'd0, |w[49:0]};
    sum = (x[31] == y[31]) ? bx + by : bx - by;
    m.sig = sum;
    m.e   = $signed({4'd0, fp_eexp(x)}) + 12'sd1;
    m.sgn = (sum == 50'd0) ? (x[31] & y[31]) : x[31];
    if (fp_is_nan(x) || fp_is_nan(y) ||
        (fp_is_inf(x) && fp_is_inf(y) && (x[31] != y[31]))) m.cls = FC_NAN;
    else if (fp_is_inf(x) || fp_is_inf(y)) m.cls = FC_INF;
    else m.cls = FC_NUM;
    return m;
  endfunction

endpackage

// File: design/ptx_if.sv
// Valid/ready channel interfaces for input points and transformed results.
// No dependencies.
interface ptx_point_if;
  logic        valid;
  logic        ready;
  logic [31:0] point_x;
  logic [31:0] point_y;
  logic [31:0] point_z;
  modport source (output valid, output point_x, output point_y, output point_z, input ready);
  modport sink (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface ptx_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_x;
  logic [31:0] result_y;
  logic [31:0] result_z;
  modport source (output valid, output result_x, output result_y, output result_z, input ready);
  modport sink (input valid, input result_x, input result_y, input result_z, output ready);
endinterface

// File: design/point_transform_homogeneous.sv
// Top level: 4x4 homogeneous point transform with perspective divide.
// Depends on ptx_pkg, ptx_if, ptx_fmul and ptx_fadd.
//
// Usage:
//   point  (sink)   : one beat carries point_x/y/z as single-precision bit patterns.
//   result (source) : one beat per point carries result_x/y/z, in input order.
//   APB port        : eight 64-bit matrix registers at byte address 8*i, two
//                     elements per register (low half first column). Write only
//                     while no point is in flight; reads return the register.
// Pipeline: a point beat passes the dot products, the reciprocal of row 3, the
//   final multiply and the output register, in that order.
// Throughput: one point per cycle while point.ready is high; the reciprocal is a
//   9-stage restoring divider retiring three quotient bits per stage.
// Reset: matrix returns to identity, all pipeline valid bits, the output valid
//   and the skid flag clear.
// Stall: the pipeline keeps advancing while the output register holds an unaccepted
//   beat; a one-beat skid register catches the next result, and point.ready
//   drops only while that skid register is full.
module point_transform_homogeneous (
  input  logic                         clk,
  input  logic                         rst,
  ptx_point_if.sink                    point,
  ptx_result_if.source                 result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ptx_pkg::ADDR_W-1:0]   paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready
);

  typedef struct packed {
    ptx_pkg::fp_cls_t   cls;
    logic               sgn;
    logic signed [11:0] e;
    logic [23:0]        d;
    logic [24:0]        rem;
    logic [26:0]        q;
  } rcp_t;

  function automatic rcp_t rcp_iter(input rcp_t a);
    rcp_t r;
    r = a;
    for (int i = 0; i < 3; i++) begin
      if (r.rem >= {1'b0, r.d}) begin
        r.q   = {r.q[25:0], 1'b1};
        r.rem = 25'((r.rem - {1'b0, r.d}) << 1);
      end else begin
        r.q   = {r.q[25:0], 1'b0};
        r.rem = 25'(r.rem << 1);
      end
    end
    return r;
  endfunction

  logic [63:0]  cfg [ptx_pkg::REG_COUNT];
  logic [31:0]  m [4][4];
  logic         en;
  logic [21:1]  vld;
  logic [31:0]  p0 [4];
  logic [31:0]  p1 [4];
  logic [31:0]  p2 [4];
  logic [31:0]  p2d1 [4];
  logic [31:0]  p2d2 [4];
  logic [31:0]  a1 [4];
  logic [31:0]  a2 [4];
  logic [31:0]  dot [4];
  logic [127:0] dl [13];
  rcp_t         rc [10];
  rcp_t         rc_next [10];
  logic [23:0]  dm;
  logic [4:0]   lz;
  logic [31:0]  inv;
  logic [31:0]  qo [3];
  logic [31:0]  s_fin;
  logic [95:0]  pd;
  logic [95:0]  od;
  logic [95:0]  sd;
  logic         ov;
  logic         sv;
  logic         take;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ptx_pkg::REG_COUNT; i++) cfg[i] <= ptx_pkg::CFG_RESET[i];
    end else if (psel && penable && pwrite) begin
      cfg[paddr[ptx_pkg::ADDR_W-1:3]] <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = cfg[paddr[ptx_pkg::ADDR_W-1:3]];

  for (genvar r = 0; r < 4; r++) begin : g_el
    for (genvar c = 0; c < 4; c++) begin : g_col
      assign m[r][c] = (c % 2 == 1) ? cfg[r*2 + c/2][63:32] : cfg[r*2 + c/2][31:0];
    end
  end

  // pipeline advance
  assign en          = ~sv;
  assign point.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[20:1], point.valid};
    end
  end

  // row dot products
  for (genvar r = 0; r < 4; r++) begin : g_row
    ptx_fmul u_m0 (.clk(clk), .en(en), .a(m[r][0]), .b(point.point_x), .y(p0[r]));
    ptx_fmul u_m1 (.clk(clk), .en(en), .a(m[r][1]), .b(point.point_y), .y(p1[r]));
    ptx_fmul u_m2 (.clk(clk), .en(en), .a(m[r][2]), .b(point.point_z), .y(p2[r]));

    always_ff @(posedge clk) begin
      if (en) begin
        p2d1[r] <= p2[r];
        p2d2[r] <= p2d1[r];
      end
    end

    ptx_fadd u_a1 (.clk(clk), .en(en), .a(p0[r]), .b(p1[r]), .y(a1[r]));
    ptx_fadd u_a2 (.clk(clk), .en(en), .a(a1[r]), .b(p2d2[r]), .y(a2[r]));
    ptx_fadd u_a3 (.clk(clk), .en(en), .a(a2[r]), .b(m[r][3]), .y(dot[r]));
  end

  // hold rows and divisor alongside the reciprocal
  always_ff @(posedge clk) begin
    if (en) begin
      dl[0] <= {dot[3], dot[2], dot[1], dot[0]};
      for (int k = 1; k < 13; k++) dl[k] <= dl[k-1];
    end
  end

  // reciprocal: normalize divisor, then iterate
  assign dm = ptx_pkg::fp_mant(dot[3]);

  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (dm[i]) lz = 5'(23 - i);
    end
    rc_next[0].sgn = dot[3][31];
    rc_next[0].d   = dm << lz;
    rc_next[0].e   = 12'sd254 - ($signed({4'd0, ptx_pkg::fp_eexp(dot[3])}) -
                                 $signed({7'd0, lz}));
    rc_next[0].rem = 25'h080_0000;
    rc_next[0].q   = '0;
    if (ptx_pkg::fp_is_nan(dot[3])) rc_next[0].cls = ptx_pkg::FC_NAN;
    else if (ptx_pkg::fp_is_inf(dot[3]) || ptx_pkg::fp_is_zero(dot[3]))
      rc_next[0].cls = ptx_pkg::FC_ZERO;
    else rc_next[0].cls = ptx_pkg::FC_NUM;
    for (int k = 1; k < 10; k++) rc_next[k] = rcp_iter(rc[k-1]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 10; k++) rc[k] <= rc_next[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inv <= ptx_pkg::fp_finish('{cls: rc[9].cls, sgn: rc[9].sgn, e: rc[9].e,
                                  sig: {rc[9].q, 22'd0, |rc[9].rem}});
    end
  end

  // scale rows
  for (genvar i = 0; i < 3; i++) begin : g_scale
    ptx_fmul u_sc (.clk(clk), .en(en), .a(dl[10][i*32 +: 32]), .b(inv), .y(qo[i]));
    always_comb begin
      if (ptx_pkg::fp_is_zero(s_fin)) pd[i*32 +: 32] = 32'd0;
      else if (s_fin == ptx_pkg::FP_ONE) pd[i*32 +: 32] = dl[12][i*32 +: 32];
      else pd[i*32 +: 32] = qo[i];
    end
  end

  assign s_fin = dl[12][127:96];

  // output register and skid
  assign take = ov & result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (sv) begin
      if (take) begin
        ov <= 1'b1;
        sv <= 1'b0;
      end
    end else if (!ov || take) begin
      ov <= vld[21];
    end else if (vld[21]) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sv) begin
      if (take) od <= sd;
    end else if (!ov || take) begin
      od <= pd;
    end else begin
      sd <= pd;
    end
  end

  assign result.valid    = ov;
  assign result.result_x = od[31:0];
  assign result.result_y = od[63:32];
  assign result.result_z = od[95:64];

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst) sv |-> ov)
    else $error("skid register full with output register empty");
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (!sv && ov && !result.ready && vld[21]) |=> sv)
    else $error("result beat dropped while output stalled");
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (sv && result.ready) |=> (!sv && ov))
    else $error("skid register did not drain");
`endif

endmodule

// File: design/ptx_fmul.sv
// Two-stage single-precision multiplier: mantissa product, then normalize and round.
// Depends on ptx_pkg.
module ptx_fmul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  ptx_pkg::fp_mid_t mid;

  always_ff @(posedge clk) begin
    if (en) begin
      mid <= ptx_pkg::fmul_pre(a, b);
      y   <= ptx_pkg::fp_finish(mid);
    end
  end

endmodule

// File: design/ptx_fadd.sv
// Two-stage single-precision adder: align and add, then normalize and round.
// Depends on ptx_pkg.
module ptx_fadd (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  ptx_pkg::fp_mid_t mid;

  always_ff @(posedge clk) begin
    if (en) begin
      mid <= ptx_pkg::fadd_pre(a, b);
      y   <= ptx_pkg::fp_finish(mid);
    end
  end

endmodule

// File: tb/ptx_tb_types.sv
`timescale 1ns / 1ps
// Testbench types for the point transform: matrix register indexes and beat records.
// No dependencies.
package ptx_tb_types;

  typedef enum int unsigned {
    ROW0_PAIR_A, ROW0_PAIR_B, ROW1_PAIR_A, ROW1_PAIR_B,
    ROW2_PAIR_A, ROW2_PAIR_B, ROW3_PAIR_A, ROW3_PAIR_B
  } mat_reg_e;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } vec3_t;

  typedef struct {
    vec3_t point;
    bit    known;
    vec3_t want;
  } point_row_t;

endpackage

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for point_transform_homogeneous: random and directed points
// across several matrix settings, checked against a float predictor built on reals.
// Depends on ptx_pkg, ptx_if, ptx_tb_types and the block's RTL.
module tb_top;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 40;

  logic clk;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [ptx_pkg::ADDR_W-1:0] paddr;
  logic [63:0] pwdata, prdata;

  ptx_point_if  pt();
  ptx_result_if res();

  point_transform_homogeneous u_top (
    .clk(clk), .rst(rst), .point(pt), .result(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic [63:0]          mat [ptx_pkg::REG_COUNT];
  ptx_tb_types::vec3_t  transformed_q [$];
  int                   errors;
  int                   quiet_cycles;
  bit                   calm;
  bit                   hold_req;
  bit                   typed_pending;
  ptx_tb_types::vec3_t  typed_want;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic real sp_to_real(logic [31:0] a);
    logic [23:0] f;
    int          e;
    if (a[30:23] == 8'hFF) return $bitstoreal({a[31], 11'h7FF, a[22:0], 29'h0});
    if (a[30:0] == 31'h0) return $bitstoreal({a[31], 63'h0});
    if (a[30:23] == 8'h0) begin
      f = {1'b0, a[22:0]};
      e = -126;
      while (!f[23]) begin
        f = f << 1;
        e--;
      end
    end else begin
      f = {1'b1, a[22:0]};
      e = int'(a[30:23]) - 127;
    end
    return $bitstoreal({a[31], 11'(e + 1023), f[22:0], 29'h0});
  endfunction

  function automatic logic [31:0] real_to_sp(real v);
    logic [63:0] d;
    logic [63:0] m;
    logic [63:0] kept;
    logic [63:0] body;
    int          e;
    int          ee;
    int          sh;
    bit          g;
    bit          st;
    d = $realtobits(v);
    if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? ptx_pkg::CANON_NAN : {d[63], 8'hFF, 23'h0};
    if (d[62:0] == 63'h0) return {d[63], 31'h0};
    e  = int'(d[62:52]) - 1023;
    m  = {11'h0, 1'b1, d[51:0]};
    ee = (e < -126) ? -126 : e;
    sh = 29 + (ee - e);
    if (sh > 60) return {d[63], 31'h0};
    kept = m >> sh;
    g    = m[sh-1];
    st   = (m & ((64'd1 << (sh - 1)) - 64'd1)) != 0;
    kept = kept + 64'(g & (st | kept[0]));
    body = (64'(ee + 126) << 23) + kept;
    if (body >= (64'd255 << 23)) return {d[63], 8'hFF, 23'h0};
    return {d[63], body[30:0]};
  endfunction

  function automatic logic [31:0] sp_mul(logic [31:0] a, logic [31:0] b);
    return real_to_sp(sp_to_real(a) * sp_to_real(b));
  endfunction

  function automatic logic [31:0] sp_add(logic [31:0] a, logic [31:0] b);
    return real_to_sp(sp_to_real(a) + sp_to_real(b));
  endfunction

  function automatic logic [31:0] mat_elem(int r, int c);
    logic [63:0] pair;
    pair = mat[r * 2 + c / 2];
    return (c % 2) ? pair[63:32] : pair[31:0];
  endfunction

  function automatic logic [31:0] row_dot(int r, ptx_tb_types::vec3_t p);
    logic [31:0] acc;
    acc = sp_add(sp_mul(mat_elem(r, 0), p.x), sp_mul(mat_elem(r, 1), p.y));
    acc = sp_add(acc, sp_mul(mat_elem(r, 2), p.z));
    return sp_add(acc, mat_elem(r, 3));
  endfunction

  function automatic ptx_tb_types::vec3_t transform_point(ptx_tb_types::vec3_t p);
    ptx_tb_types::vec3_t o;
    logic [31:0]         s;
    logic [31:0]         inv;
    s = row_dot(3, p);
    if (s[30:0] == 31'h0) begin
      o.x = 32'h0;
      o.y = 32'h0;
      o.z = 32'h0;
      return o;
    end
    o.x = row_dot(0, p);
    o.y = row_dot(1, p);
    o.z = row_dot(2, p);
    if (s != ptx_pkg::FP_ONE) begin
      inv = real_to_sp(1.0 / sp_to_real(s));
      o.x = sp_mul(o.x, inv);
      o.y = sp_mul(o.y, inv);
      o.z = sp_mul(o.z, inv);
    end
    return o;
  endfunction

  function automatic logic [31:0] rand_float();
    logic [31:0] specials [8] = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                                  32'h7FC0_0001, 32'hFFFF_FFFF, 32'h3F80_0000, 32'h0000_0001};
    case ($urandom_range(7))
      0, 1, 2, 3: return {1'($urandom), 8'($urandom_range(140, 112)), 23'($urandom)};
      4:          return $urandom;
      5:          return specials[$urandom_range(7)];
      6:          return {1'($urandom), 8'($urandom_range(129, 126)), 23'($urandom) & 23'h7F0000};
      default:    return {1'($urandom), ($urandom_range(1) ? 8'($urandom_range(254, 250)) :
                                                            8'($urandom_range(2))), 23'($urandom)};
    endcase
  endfunction

  function automatic logic [31:0] rand_moderate();
    return {1'($urandom), 8'($urandom_range(130, 122)), 23'($urandom)};
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic reg_write(ptx_tb_types::mat_reg_e idx, logic [63:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ptx_pkg::ADDR_W'(idx * 8);
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    mat[idx] = val;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_idle();
    pt.valid <= 1'b0;
    while (transformed_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_point(ptx_tb_types::vec3_t p, bit known, ptx_tb_types::vec3_t want);
    while (!calm && $urandom_range(99) < 33) begin
      pt.valid <= 1'b0;
      @(negedge clk);
    end
    typed_pending = known;
    typed_want    = want;
    pt.valid   <= 1'b1;
    pt.point_x <= p.x;
    pt.point_y <= p.y;
    pt.point_z <= p.z;
    @(posedge clk);
    while (!pt.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(int n, bit moderate);
    ptx_tb_types::vec3_t p;
    ptx_tb_types::vec3_t none;
    none = '{32'h0, 32'h0, 32'h0};
    repeat (n) begin
      p.x = moderate ? rand_moderate() : rand_float();
      p.y = moderate ? rand_moderate() : rand_float();
      p.z = moderate ? rand_moderate() : rand_float();
      send_point(p, 1'b0, none);
    end
  endtask

  task automatic load_matrix(bit full_bits);
    for (int i = 0; i < ptx_pkg::REG_COUNT; i++) begin
      reg_write(ptx_tb_types::mat_reg_e'(i),
                full_bits ? {$urandom, $urandom} : {rand_moderate(), rand_moderate()});
    end
  endtask

  // accepted points feed the predictor; directed rows may carry a typed answer
  always @(posedge clk) begin
    if (!rst && pt.valid && pt.ready) begin
      if (typed_pending) transformed_q.push_back(typed_want);
      else transformed_q.push_back(transform_point('{pt.point_x, pt.point_y, pt.point_z}));
    end
  end

  always @(posedge clk) begin
    ptx_tb_types::vec3_t want;
    if (!rst && res.valid && res.ready) begin
      if (transformed_q.size() == 0) begin
        report("unexpected beat", res.result_x, 32'h0);
      end else begin
        want = transformed_q.pop_front();
        if (res.result_x !== want.x) report("result_x", res.result_x, want.x);
        if (res.result_y !== want.y) report("result_y", res.result_y, want.y);
        if (res.result_z !== want.z) report("result_z", res.result_z, want.z);
      end
    end
  end

  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res.ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end
      res.ready <= calm ? 1'b1 : ($urandom_range(99) >= 33);
    end
  end

  always @(posedge clk) begin
    if (rst || (pt.valid && pt.ready) || (res.valid && res.ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    ptx_tb_types::point_row_t rows [$];
    ptx_tb_types::vec3_t      none;
    none = '{32'h0, 32'h0, 32'h0};
    rows = '{
      '{'{32'h3F80_0000, 32'h4000_0000, 32'hC040_0000}, 1'b1,
        '{32'h3F80_0000, 32'h4000_0000, 32'hC040_0000}},
      '{'{32'h7F7F_FFFF, 32'h0000_0001, 32'h3F80_0000}, 1'b1,
        '{32'h7F7F_FFFF, 32'h0000_0001, 32'h3F80_0000}},
      '{'{32'hFF7F_FFFF, 32'h807F_FFFF, 32'h0080_0000}, 1'b1,
        '{32'hFF7F_FFFF, 32'h807F_FFFF, 32'h0080_0000}},
      '{'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b0, none},
      '{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1'b0, none},
      '{'{32'h7F80_0000, 32'h3F80_0000, 32'h3F80_0000}, 1'b0, none},
      '{'{32'hFF80_0000, 32'hFF80_0000, 32'h7F80_0000}, 1'b0, none},
      '{'{32'h7FC0_0000, 32'h3F80_0000, 32'h3F80_0000}, 1'b0, none},
      '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, none},
      '{'{32'h0000_0000, 32'hFFFF_FFFF, 32'h7F80_0001}, 1'b0, none},
      '{'{32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333}, 1'b0, none},
      '{'{32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCC}, 1'b0, none}
    };
    errors = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    typed_pending = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pt.valid = 1'b0;
    pt.point_x = '0;
    pt.point_y = '0;
    pt.point_z = '0;
    for (int i = 0; i < ptx_pkg::REG_COUNT; i++) mat[i] = ptx_pkg::CFG_RESET[i];
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[i]) send_point(rows[i].point, rows[i].known, rows[i].want);
    send_random(60, 1'b0);
    typed_pending = 1'b0;

    // unit divisor, no idling on either side
    wait_idle();
    load_matrix(1'b0);
    reg_write(ptx_tb_types::ROW3_PAIR_A, 64'h0);
    reg_write(ptx_tb_types::ROW3_PAIR_B, {ptx_pkg::FP_ONE, 32'h0});
    calm = 1'b1;
    send_random(100, 1'b1);
    calm = 1'b0;

    // perspective: divisor is z
    wait_idle();
    reg_write(ptx_tb_types::ROW3_PAIR_A, 64'h0);
    reg_write(ptx_tb_types::ROW3_PAIR_B, {32'h0, ptx_pkg::FP_ONE});
    send_random(100, 1'b0);

    // random matrix, receiver holds off while points keep coming
    wait_idle();
    load_matrix(1'b0);
    hold_req = 1'b1;
    send_random(120, 1'b1);

    wait_idle();
    for (int i = 0; i < ptx_pkg::REG_COUNT; i++) begin
      reg_write(ptx_tb_types::mat_reg_e'(i), 64'hFFFF_FFFF_FFFF_FFFF);
    end
    send_random(40, 1'b0);

    wait_idle();
    for (int i = 0; i < ptx_pkg::REG_COUNT; i++) begin
      reg_write(ptx_tb_types::mat_reg_e'(i), 64'h0);
    end
    send_random(40, 1'b0);

    wait_idle();
    load_matrix(1'b1);
    send_random(100, 1'b0);

    // divisor near the edges of the range
    wait_idle();
    load_matrix(1'b0);
    reg_write(ptx_tb_types::ROW3_PAIR_A, {32'h0000_0001, 32'h0});
    reg_write(ptx_tb_types::ROW3_PAIR_B, {32'h7F7F_FFFF, 32'h0080_0000});
    send_random(120, 1'b0);
    wait_idle();
    reg_write(ptx_tb_types::ROW3_PAIR_B, {32'h0000_0001, 32'h0});
    send_random(100, 1'b0);

    wait_idle();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
